@@ rtl/core/sbf_pkg.sv @@
`timescale 1ns / 1ps
package sbf_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int CHANNEL_COUNT = 16;
    localparam int PAYLOAD_BYTES = 22;
    localparam int BYTE_W        = 8;
    localparam int RAW_W         = 11;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
    localparam int POS_W         = $clog2(FRAME_BYTES + 1);
    localparam int CH_W          = $clog2(CHANNEL_COUNT);
    localparam int VAL_W         = 16;
    localparam int CNT_W         = 32;
    localparam int CFG_IDX_W     = 2;

    // Mapping datapath widths.
    localparam int DIFF_W  = RAW_W + 1;
    localparam int OSPAN_W = VAL_W + 1;
    localparam int PROD_W  = DIFF_W + OSPAN_W;
    localparam int SUM_W   = PROD_W + 2;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_MIN  = 2'd0,
        CFG_INPUT_MAX  = 2'd1,
        CFG_OUTPUT_MIN = 2'd2,
        CFG_OUTPUT_MAX = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        RX_HUNT = 1'b0,
        RX_FILL = 1'b1
    } rx_state_t;

    typedef enum logic [2:0] {
        MAP_IDLE   = 3'd0,
        MAP_LOAD   = 3'd1,
        MAP_MUL    = 3'd2,
        MAP_START  = 3'd3,
        MAP_DIVIDE = 3'd4,
        MAP_FINISH = 3'd5,
        MAP_EMIT   = 3'd6
    } map_state_t;

    typedef struct packed {
        logic [RAW_W-1:0]        input_min;
        logic [RAW_W-1:0]        input_max;
        logic signed [VAL_W-1:0] output_min;
        logic signed [VAL_W-1:0] output_max;
    } sbf_cfg_t;

    // Requests from the channel sequencer to the frame payload register.
    typedef struct packed {
        logic busy;
        logic shift;
    } sbf_map_ctl_t;

endpackage

@@ rtl/core/sbf_divider.sv @@
`timescale 1ns / 1ps
module sbf_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sbf_pkg::PROD_W-1:0] dividend,
    input  logic [sbf_pkg::RAW_W-1:0]  divisor,
    output logic                       done,
    output logic [sbf_pkg::PROD_W-1:0] quotient
);
    import sbf_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [RAW_W-1:0]  rem_reg;
    logic [RAW_W-1:0]  div_reg;

    logic [RAW_W:0]    rem_shift;
    logic [RAW_W+1:0]  trial;
    logic              qbit;

    // One restoring step per cycle: the dividend shifts out of the top of acc_reg
    // while quotient bits fill in from the bottom.
    always_comb
    begin
        rem_shift = {rem_reg, acc_reg[PROD_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, div_reg};
        qbit      = !trial[RAW_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(PROD_W - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == '0);
            busy_reg <= (step_reg != '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[PROD_W-2:0], qbit};
            rem_reg <= qbit ? trial[RAW_W-1:0] : rem_shift[RAW_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

@@ rtl/core/sbf_channel_map.sv @@
`timescale 1ns / 1ps
module sbf_channel_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  sbf_pkg::sbf_cfg_t               cfg,
    input  logic [sbf_pkg::RAW_W-1:0]       raw,
    output sbf_pkg::sbf_map_ctl_t           ctl,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sbf_pkg::CH_W-1:0]        out_index,
    output logic signed [sbf_pkg::VAL_W-1:0] out_value,
    output logic                            out_last
);
    import sbf_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);
    localparam logic [CH_W-1:0]         CH_LAST = CH_W'(CHANNEL_COUNT - 1);

    map_state_t state_reg;
    map_state_t state_next;

    logic [CH_W-1:0]          ch_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [OSPAN_W-1:0] ospan_reg;
    logic signed [DIFF_W-1:0] den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  value_reg;

    logic                     div_start;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quotient;
    logic [PROD_W-1:0]        prod_mag;
    logic [RAW_W-1:0]         den_mag;
    logic                     den_zero;
    logic                     negative;
    logic signed [PROD_W:0]   quo_signed;
    logic signed [SUM_W-1:0]  sum;
    logic signed [VAL_W-1:0]  mapped;
    logic                     emit_done;

    always_comb
    begin
        prod_mag   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        den_mag    = den_reg[DIFF_W-1] ? RAW_W'(-den_reg) : RAW_W'(den_reg);
        den_zero   = (den_reg == '0);
        negative   = prod_reg[PROD_W-1] ^ den_reg[DIFF_W-1];
        quo_signed = negative ? -$signed({1'b0, div_quotient})
                              : $signed({1'b0, div_quotient});
        sum        = SUM_W'(quo_signed) + SUM_W'(cfg.output_min);
        priority if (den_zero)
            mapped = cfg.output_min;
        else if (sum > SAT_HI)
            mapped = VAL_W'(SAT_HI);
        else if (sum < SAT_LO)
            mapped = VAL_W'(SAT_LO);
        else
            mapped = sum[VAL_W-1:0];
        emit_done = out_ready && (state_reg == MAP_EMIT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MAP_IDLE:   if (start) state_next = MAP_LOAD;
            MAP_LOAD:   state_next = MAP_MUL;
            MAP_MUL:    state_next = MAP_START;
            MAP_START:  state_next = den_zero ? MAP_FINISH : MAP_DIVIDE;
            MAP_DIVIDE: if (div_done) state_next = MAP_FINISH;
            MAP_FINISH: state_next = MAP_EMIT;
            MAP_EMIT:
            begin
                if (out_ready)
                    state_next = (ch_reg == CH_LAST) ? MAP_IDLE : MAP_LOAD;
            end
            default:    state_next = MAP_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = (state_reg == MAP_START) && !den_zero;
        ctl.busy  = (state_reg != MAP_IDLE);
        ctl.shift = (state_reg == MAP_FINISH);
        out_valid = (state_reg == MAP_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAP_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && state_reg == MAP_IDLE)
                ch_reg <= '0;
            else if (emit_done)
                ch_reg <= ch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MAP_LOAD)
        begin
            diff_reg  <= $signed({1'b0, raw}) - $signed({1'b0, cfg.input_min});
            den_reg   <= $signed({1'b0, cfg.input_max}) - $signed({1'b0, cfg.input_min});
            ospan_reg <= OSPAN_W'(cfg.output_max) - OSPAN_W'(cfg.output_min);
        end
        if (state_reg == MAP_MUL)
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(ospan_reg);
        if (state_reg == MAP_FINISH)
            value_reg <= mapped;
    end

    sbf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_index = ch_reg;
    assign out_value = value_reg;
    assign out_last  = (ch_reg == CH_LAST);

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == MAP_IDLE)
        else $error("frame decode started while a frame is still being mapped");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == MAP_DIVIDE)
        else $error("divider finished outside of the divide step");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_done && out_last) |=> state_reg == MAP_IDLE)
        else $error("sequencer kept running after the last channel");

    a_shift_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |=> !ctl.shift && state_reg == MAP_EMIT)
        else $error("payload shifted more than once for one channel");

endmodule

@@ rtl/core/sbus_frame_receiver.sv @@
`timescale 1ns / 1ps
// S.BUS frame receiver with linear channel mapping.
//
// Slave stream: one item per received byte. s_tdata carries the byte, s_tuser
// marks a line-idle timeout, which drops the receiver back to header hunting.
// A byte is taken when the sequencer is idle. Bytes 1 to 22 shift into a payload
// register; when the footer byte of a frame arrives and is zero, the good-frame
// counter increments and the channel sequencer starts.
//
// Master stream: sixteen items per good frame, channel 0 first, m_tlast on
// channel 15. Each channel steps through load, multiply, start, 29 steps of the
// shared serial divider, finish, then the output state. With input_max equal to
// input_min the divider is skipped. s_tready stays low until the last item of
// the frame has been taken; a stall on m_tready simply holds the current item
// and the sequencer.
//
// The configuration channel writes one mapping register per item; it is always
// ready. Reset returns the block to hunting, clears the frame counter and loads
// the default mapping (172..1811 to 1000..2000).
module sbus_frame_receiver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic [0:0]                         s_tuser,   // [0] operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,   // [15:0] channel_value,
                                                          // [47:16] good_frame_count
    output logic [3:0]                         m_tuser,   // [3:0] channel_index
    output logic                               m_tlast,   // last_channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                        cfg_data
);
    import sbf_pkg::*;

    sbf_cfg_t             cfg_reg;
    rx_state_t            rx_state_reg;
    rx_state_t            rx_state_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [CNT_W-1:0]     frames_reg;

    sbf_map_ctl_t         map_ctl;
    logic                 in_accept;
    logic                 is_timeout;
    logic                 pos_bad;
    logic                 pos_footer;
    logic                 store_byte;
    logic                 frame_good;
    logic signed [VAL_W-1:0] value;

    assign s_tready   = !map_ctl.busy;
    assign cfg_ready  = 1'b1;
    assign in_accept  = s_tvalid && s_tready;
    assign is_timeout = s_tuser[0];
    assign pos_bad    = (pos_reg == '0) || (pos_reg >= POS_W'(FRAME_BYTES));
    assign pos_footer = (pos_reg == POS_W'(FRAME_BYTES - 1));

    always_comb
    begin
        rx_state_next = rx_state_reg;
        pos_next      = pos_reg;
        if (in_accept)
        begin
            priority if (is_timeout)
                rx_state_next = RX_HUNT;
            else if (rx_state_reg == RX_HUNT)
            begin
                if (s_tdata == HEADER_BYTE)
                begin
                    rx_state_next = RX_FILL;
                    pos_next      = POS_W'(1);
                end
            end
            else if (pos_bad || pos_footer)
            begin
                rx_state_next = RX_HUNT;
                pos_next      = '0;
            end
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        store_byte = in_accept && !is_timeout && (rx_state_reg == RX_FILL) && !pos_bad
                     && (pos_reg <= POS_W'(PAYLOAD_BYTES));
        frame_good = in_accept && !is_timeout && (rx_state_reg == RX_FILL) && pos_footer
                     && (s_tdata == FOOTER_BYTE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_state_reg <= RX_HUNT;
            pos_reg      <= '0;
            frames_reg   <= '0;
        end
        else
        begin
            rx_state_reg <= rx_state_next;
            pos_reg      <= pos_next;
            if (frame_good)
                frames_reg <= frames_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_min  <= RAW_W'(172);
            cfg_reg.input_max  <= RAW_W'(1811);
            cfg_reg.output_min <= VAL_W'(1000);
            cfg_reg.output_max <= VAL_W'(2000);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_INPUT_MIN:  cfg_reg.input_min  <= cfg_data[RAW_W-1:0];
                CFG_INPUT_MAX:  cfg_reg.input_max  <= cfg_data[RAW_W-1:0];
                CFG_OUTPUT_MIN: cfg_reg.output_min <= cfg_data;
                CFG_OUTPUT_MAX: cfg_reg.output_max <= cfg_data;
                default:        cfg_reg.output_max <= cfg_reg.output_max;
            endcase
        end
    end

    // Bytes enter at the top so byte 1 ends up in the low bits; the sequencer
    // then drops one 11-bit channel off the bottom per channel.
    always_ff @(posedge clk)
    begin
        if (store_byte)
            payload_reg <= {s_tdata, payload_reg[PAYLOAD_W-1:BYTE_W]};
        else if (map_ctl.shift)
            payload_reg <= {{RAW_W{1'b0}}, payload_reg[PAYLOAD_W-1:RAW_W]};
    end

    sbf_channel_map u_channel_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (frame_good),
        .cfg       (cfg_reg),
        .raw       (payload_reg[RAW_W-1:0]),
        .ctl       (map_ctl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (m_tuser),
        .out_value (value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {frames_reg, value};

endmodule
